@@ hdl/pqsa_pkg.sv @@
// Shared types and constants for the priority queue and stack arbiter.
`default_nettype none

package pqsa_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int CNT_W           = 5;

    // Bit 1 of the command selects a serve; otherwise code zero pushes, the rest inserts.
    localparam int         CMD_SERVE_BIT = 1;
    localparam logic [1:0] CMD_PUSH      = 2'd0;

    typedef enum logic [2:0] {
        ST_ACCEPTED = 3'd0,
        ST_FULL     = 3'd1,
        ST_SERVED_Q = 3'd2,
        ST_SERVED_S = 3'd3,
        ST_EMPTY    = 3'd4
    } t_status;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] flight_id;
        logic [7:0]  severity;
        logic [10:0] time_minutes;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [15:0]      out_flight_id;
        logic [7:0]       out_severity;
        logic [10:0]      out_time_minutes;
        logic [CNT_W-1:0] queue_count;
        logic [CNT_W-1:0] stack_count;
    } t_res;

    typedef struct packed {
        logic [15:0] flight_id;
        logic [7:0]  severity;
        logic [10:0] time_minutes;
    } t_qcell;

    typedef struct packed {
        logic [15:0] flight_id;
        logic [10:0] time_minutes;
    } t_scell;

    typedef struct packed {
        logic    capture;
        logic    q_insert;
        logic    q_pop;
        logic    s_push;
        logic    s_pop;
        logic    load_res;
        t_status res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       q_empty;
        logic       q_full;
        logic       s_empty;
        logic       s_full;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ hdl/pqsa_dp.sv @@
// Datapath: sorted queue cells, stack memory, request and result registers.
`default_nettype none

module pqsa_dp
    import pqsa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_req     i_req,
    input  wire t_dp_cmd  i_cmd,
    output t_dp_stat      o_stat,
    output t_res          o_res
);

    localparam int QFW = $clog2(QUEUE_DEPTH + 1);
    localparam int SFW = $clog2(STACK_DEPTH + 1);
    localparam int SAW = $clog2(STACK_DEPTH);

    t_req              r_req;
    t_res              r_res;
    t_res              n_res;
    t_qcell            r_cell [QUEUE_DEPTH];
    t_qcell            n_cell [QUEUE_DEPTH];
    t_qcell            ins_cell;
    logic [QUEUE_DEPTH-1:0] ahead;
    logic [QFW-1:0]    r_q_fill;
    logic [QFW-1:0]    n_q_fill;
    t_scell            r_mem [STACK_DEPTH];
    t_scell            r_rd_data;
    logic [SFW-1:0]    r_s_fill;
    logic [SFW-1:0]    n_s_fill;
    logic [SFW-1:0]    s_top;

    assign ins_cell = '{flight_id: r_req.flight_id, severity: r_req.severity,
                        time_minutes: r_req.time_minutes};
    assign s_top    = r_s_fill - SFW'(1);

    assign o_stat.cmd     = r_req.cmd;
    assign o_stat.q_empty = (r_q_fill == '0);
    assign o_stat.q_full  = (r_q_fill >= QFW'(QUEUE_DEPTH));
    assign o_stat.s_empty = (r_s_fill == '0);
    assign o_stat.s_full  = (r_s_fill >= SFW'(STACK_DEPTH));
    assign o_res          = r_res;

    // Each occupied cell decides on its own whether it stays ahead of the new entry.
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            ahead[i] = (QFW'(i) < r_q_fill) &&
                       ((r_cell[i].severity > r_req.severity) ||
                        ((r_cell[i].severity == r_req.severity) &&
                         (r_cell[i].time_minutes < r_req.time_minutes)));
        end
    end

    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        always_comb begin
            n_cell[g] = r_cell[g];
            if (i_cmd.q_insert && !ahead[g]) begin
                if (g == 0) begin
                    n_cell[g] = ins_cell;
                end else if (ahead[(g == 0) ? 0 : g-1]) begin
                    n_cell[g] = ins_cell;
                end else begin
                    n_cell[g] = r_cell[(g == 0) ? 0 : g-1];
                end
            end else if (i_cmd.q_pop && (g < QUEUE_DEPTH-1)) begin
                n_cell[g] = r_cell[(g < QUEUE_DEPTH-1) ? g+1 : g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[g] <= n_cell[g];
        end
    end

    always_comb begin
        n_q_fill = r_q_fill;
        if (i_cmd.q_insert) begin
            n_q_fill = r_q_fill + QFW'(1);
        end else if (i_cmd.q_pop) begin
            n_q_fill = r_q_fill - QFW'(1);
        end
        n_s_fill = r_s_fill;
        if (i_cmd.s_push) begin
            n_s_fill = r_s_fill + SFW'(1);
        end else if (i_cmd.s_pop) begin
            n_s_fill = s_top;
        end
    end

    always_comb begin
        n_res                  = r_res;
        n_res.status           = i_cmd.res_status;
        n_res.out_flight_id    = '0;
        n_res.out_severity     = '0;
        n_res.out_time_minutes = '0;
        n_res.queue_count      = CNT_W'(n_q_fill);
        n_res.stack_count      = CNT_W'(n_s_fill);
        case (i_cmd.res_status)
            ST_SERVED_Q: begin
                n_res.out_flight_id    = r_cell[0].flight_id;
                n_res.out_severity     = r_cell[0].severity;
                n_res.out_time_minutes = r_cell[0].time_minutes;
            end
            ST_SERVED_S: begin
                n_res.out_flight_id    = r_rd_data.flight_id;
                n_res.out_time_minutes = r_rd_data.time_minutes;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_fill <= '0;
            r_s_fill <= '0;
        end else begin
            r_q_fill <= n_q_fill;
            r_s_fill <= n_s_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.load_res) begin
            r_res <= n_res;
        end
    end

    // Stack store: one write port at the fill point, registered read of the top.
    always_ff @(posedge i_clk) begin
        if (i_cmd.s_push) begin
            r_mem[r_s_fill[SAW-1:0]] <= '{flight_id: r_req.flight_id,
                                          time_minutes: r_req.time_minutes};
        end
        if (i_cmd.s_pop) begin
            r_rd_data <= r_mem[s_top[SAW-1:0]];
        end
    end

endmodule

`default_nettype wire

@@ hdl/pqsa_ctrl.sv @@
// Controller: sequences one command through the datapath and strobes the result.
`default_nettype none

module pqsa_ctrl
    import pqsa_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_busy,
    output logic          o_valid
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_STACK_RD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_valid;
    logic   n_valid;

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state          = r_state;
        n_valid          = 1'b0;
        o_cmd            = '0;
        o_cmd.res_status = ST_ACCEPTED;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                o_cmd.load_res = 1'b1;
                if (i_stat.cmd[CMD_SERVE_BIT]) begin
                    if (!i_stat.q_empty) begin
                        o_cmd.q_pop      = 1'b1;
                        o_cmd.res_status = ST_SERVED_Q;
                    end else if (!i_stat.s_empty) begin
                        // wait in S_STACK_RD for the registered stack read data
                        o_cmd.s_pop    = 1'b1;
                        o_cmd.load_res = 1'b0;
                        n_valid        = 1'b0;
                        n_state        = S_STACK_RD;
                    end else begin
                        o_cmd.res_status = ST_EMPTY;
                    end
                end else if (i_stat.cmd == CMD_PUSH) begin
                    if (i_stat.s_full) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.s_push = 1'b1;
                    end
                end else begin
                    if (i_stat.q_full) begin
                        o_cmd.res_status = ST_FULL;
                    end else begin
                        o_cmd.q_insert = 1'b1;
                    end
                end
            end
            S_STACK_RD: begin
                o_cmd.load_res   = 1'b1;
                o_cmd.res_status = ST_SERVED_S;
                n_valid          = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

@@ hdl/priority_queue_and_stack_arbiter.sv @@
// Top level: strict-priority arbiter over a sorted queue and a stack.
//
// A command transfer happens at a rising edge with start high and busy low;
// i_req carries the command (push to stack, insert into sorted queue, serve)
// and the request fields. Every command produces exactly one result on
// o_res, shown for one cycle with o_valid high; the receiver cannot stall.
// The result carries the status, the served entry (zeros when nothing was
// served) and both store counts after the command.
// The result is registered as the EXEC state ends, or as the STACK_RD state
// ends for a serve taken from the stack, whose entry comes through the
// registered read port of the stack memory. busy drops in the o_valid cycle,
// so a new command can be taken at the edge that ends it, not before.
// The sorted queue is a row of cells that all compare against the new entry
// at once and shift in place on an insert or a serve.
// Reset empties both stores at once through their fill counts; no clearing
// pass runs, and a command may start as soon as reset is released.
`default_nettype none

module priority_queue_and_stack_arbiter
    import pqsa_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_res      o_res
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    pqsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    pqsa_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat),
        .o_res   (o_res)
    );

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while a command is still in flight");

    a_start_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not make the block busy");

    a_empty_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_res.status == ST_EMPTY)) |->
            ((o_res.queue_count == '0) && (o_res.stack_count == '0)))
        else $error("empty status reported with entries held");

endmodule

`default_nettype wire

@@ tb/tb_priority_queue_and_stack_arbiter.sv @@
// Self-checking testbench for the priority queue and stack arbiter.
module tb_priority_queue_and_stack_arbiter;
    timeunit 1ns;
    timeprecision 1ps;

    import pqsa_pkg::*;

    localparam int         Q_DEPTH     = QUEUE_DEPTH_DEF;
    localparam int         S_DEPTH     = STACK_DEPTH_DEF;
    localparam logic [1:0] CMD_INSERT  = 2'd1;
    localparam logic [1:0] CMD_SERVE   = 2'd2;
    localparam logic [1:0] CMD_SERVE_X = 2'd3;  // unused code, decodes as serve
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_WAIT  = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_res o_res;

    priority_queue_and_stack_arbiter i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of both stores
    t_qcell sorted_cells[Q_DEPTH];
    int     sorted_fill = 0;
    t_scell stack_cells[S_DEPTH];
    int     stack_fill = 0;

    t_res   pending_results[$];
    bit     gaps_on = 1'b1;
    int     cycle_count = 0;
    int     mismatches = 0;
    int     results_seen = 0;
    int     served_queue = 0;
    int     served_stack = 0;
    int     rejected = 0;
    int     empty_serves = 0;
    int     commands_sent = 0;

    // Apply one command to the shadow stores and return the outcome it must give.
    function automatic t_res apply_command(t_req req);
        t_res res;
        int   pos;
        res = '0;
        if (req.cmd[CMD_SERVE_BIT]) begin
            if (sorted_fill > 0) begin
                res.status           = ST_SERVED_Q;
                res.out_flight_id    = sorted_cells[0].flight_id;
                res.out_severity     = sorted_cells[0].severity;
                res.out_time_minutes = sorted_cells[0].time_minutes;
                for (int i = 0; i < sorted_fill - 1; i++)
                    sorted_cells[i] = sorted_cells[i + 1];
                sorted_fill--;
            end else if (stack_fill > 0) begin
                stack_fill--;
                res.status           = ST_SERVED_S;
                res.out_flight_id    = stack_cells[stack_fill].flight_id;
                res.out_time_minutes = stack_cells[stack_fill].time_minutes;
            end else begin
                res.status = ST_EMPTY;
            end
        end else if (req.cmd == CMD_PUSH) begin
            if (stack_fill >= S_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                stack_cells[stack_fill].flight_id    = req.flight_id;
                stack_cells[stack_fill].time_minutes = req.time_minutes;
                stack_fill++;
                res.status = ST_ACCEPTED;
            end
        end else begin
            if (sorted_fill >= Q_DEPTH) begin
                res.status = ST_FULL;
            end else begin
                // held entry stays ahead on higher severity, or equal severity and earlier time
                pos = 0;
                while (pos < sorted_fill &&
                       (sorted_cells[pos].severity > req.severity ||
                        (sorted_cells[pos].severity == req.severity &&
                         sorted_cells[pos].time_minutes < req.time_minutes)))
                    pos++;
                for (int i = sorted_fill; i > pos; i--)
                    sorted_cells[i] = sorted_cells[i - 1];
                sorted_cells[pos].flight_id    = req.flight_id;
                sorted_cells[pos].severity     = req.severity;
                sorted_cells[pos].time_minutes = req.time_minutes;
                sorted_fill++;
                res.status = ST_ACCEPTED;
            end
        end
        res.queue_count = sorted_fill[CNT_W-1:0];
        res.stack_count = stack_fill[CNT_W-1:0];
        return res;
    endfunction

    // Called right after a rising edge; returns at the edge that takes the transfer.
    task automatic send_request(input t_req req);
        logic taken;
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !busy;
            @(posedge i_clk);
        end
        pending_results.push_back(apply_command(req));
        commands_sent++;
    endtask

    function automatic t_req make_request(logic [1:0] cmd, logic [15:0] id,
                                          logic [7:0] sev, logic [10:0] tmin);
        t_req req;
        req.cmd          = cmd;
        req.flight_id    = id;
        req.severity     = sev;
        req.time_minutes = tmin;
        return req;
    endfunction

    // Random command drawn by weight; keys often collide to exercise tie ordering.
    function automatic t_req random_request(int push_w, int insert_w, int serve_w);
        t_req req;
        int   pick;
        int   roll;
        pick = $urandom_range(0, push_w + insert_w + serve_w - 1);
        if (pick < push_w)
            req.cmd = CMD_PUSH;
        else if (pick < push_w + insert_w)
            req.cmd = CMD_INSERT;
        else
            req.cmd = ($urandom_range(0, 3) == 0) ? CMD_SERVE_X : CMD_SERVE;
        req.flight_id = 16'($urandom);
        roll = $urandom_range(0, 3);
        if (roll == 0)
            req.severity = 8'hFF;
        else if (roll == 1)
            req.severity = 8'($urandom_range(0, 3));
        else
            req.severity = 8'($urandom);
        roll = $urandom_range(0, 7);
        if (roll == 0)
            req.time_minutes = 11'($urandom_range(0, 2047));
        else if (roll < 3)
            req.time_minutes = 11'($urandom_range(0, 3));
        else if (roll == 3)
            req.time_minutes = 11'd1439;
        else
            req.time_minutes = 11'($urandom_range(0, 1439));
        return req;
    endfunction

    task automatic test_empty_serve();
        send_request(make_request(CMD_SERVE, 16'hFFFF, 8'hFF, 11'h7FF));
        send_request(make_request(CMD_SERVE_X, 16'h0000, 8'h00, 11'd0));
    endtask

    task automatic test_stack_lifo();
        // severity on a push is dropped; served severity reads zero
        send_request(make_request(CMD_PUSH, 16'h0000, 8'hFF, 11'd0));
        send_request(make_request(CMD_PUSH, 16'hFFFF, 8'h00, 11'd1439));
        send_request(make_request(CMD_PUSH, 16'h1234, 8'h80, 11'h7FF));
        repeat (4) send_request(make_request(CMD_SERVE, 16'h0, 8'h0, 11'd0));
    endtask

    task automatic test_queue_order();
        send_request(make_request(CMD_INSERT, 16'hA001, 8'd5, 11'd100));
        send_request(make_request(CMD_INSERT, 16'hA002, 8'd5, 11'd100));  // newer goes ahead
        send_request(make_request(CMD_INSERT, 16'hA003, 8'd5, 11'd50));
        send_request(make_request(CMD_INSERT, 16'hA004, 8'hFF, 11'h7FF));
        send_request(make_request(CMD_INSERT, 16'hA005, 8'd0, 11'd0));
        send_request(make_request(CMD_PUSH, 16'hB001, 8'd9, 11'd7));
        // queue drains ahead of the stack
        repeat (7) send_request(make_request(CMD_SERVE_X, 16'h0, 8'h0, 11'd0));
    endtask

    // Phases of fill, drain and mixed traffic, swinging the stores between empty and full.
    task automatic test_random_traffic(int item_goal);
        int stop_at;
        int len;
        stop_at = commands_sent + item_goal;
        while (commands_sent < stop_at) begin
            gaps_on = ($urandom_range(0, 2) != 0);
            len = $urandom_range(10, 40);
            case ($urandom_range(0, 4))
                0: repeat (len) send_request(random_request(4, 4, 1));
                1: repeat (len) send_request(random_request(1, 1, 6));
                2: repeat (len) send_request(random_request(6, 0, 2));
                3: repeat (len) send_request(random_request(0, 6, 2));
                default: repeat (len) send_request(random_request(1, 1, 1));
            endcase
        end
    endtask

    task automatic test_back_to_back(int item_goal);
        gaps_on = 1'b0;
        repeat (item_goal) send_request(random_request(2, 2, 3));
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still expected", $time,
                     pending_results.size());
            $display("status: fail");
            $finish;
        end
    end

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Results are held for one cycle only; sample mid-cycle
    always @(negedge i_clk) begin
        t_res want;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got %h", $time, o_res);
            end else begin
                want = pending_results.pop_front();
                check_field("status", 16'(want.status), 16'(o_res.status));
                check_field("out_flight_id", want.out_flight_id, o_res.out_flight_id);
                check_field("out_severity", 16'(want.out_severity),
                            16'(o_res.out_severity));
                check_field("out_time_minutes", 16'(want.out_time_minutes),
                            16'(o_res.out_time_minutes));
                check_field("queue_count", 16'(want.queue_count),
                            16'(o_res.queue_count));
                check_field("stack_count", 16'(want.stack_count),
                            16'(o_res.stack_count));
                case (want.status)
                    ST_SERVED_Q: served_queue++;
                    ST_SERVED_S: served_stack++;
                    ST_FULL:     rejected++;
                    ST_EMPTY:    empty_serves++;
                    default:     ;
                endcase
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_serve();
        test_stack_lifo();
        test_queue_order();
        test_random_traffic(1000);
        test_back_to_back(180);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0t: %0d expected results never arrived", $time,
                     pending_results.size());
        end
        $display("%0d commands, %0d results checked, %0d mismatches", commands_sent,
                 results_seen, mismatches);
        $display("served %0d from queue, %0d from stack; %0d full rejects, %0d empty serves",
                 served_queue, served_stack, rejected, empty_serves);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
